[sv/vmf_pkg.sv]
// ----------------------------------------------------------------------------
// vmf_pkg
// types and constants shared by the vector median filter modules
// ----------------------------------------------------------------------------
package vmf_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int PIX_W      = 24;
    localparam int WIN_N      = 9;
    localparam int SUM_W      = 13;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int SQ_PIPE    = 3;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic             run_last;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // latch input pixel, read line stores
        logic capture;   // capture line store data into window
        logic clear_acc;
        logic acc;       // accumulate one distance term
        logic choose;    // finish one candidate
        logic [3:0] k;
        logic [3:0] c;
        logic store;     // write line stores, shift window
    } dp_cmd_t;

    // floor square root of an 18-bit value, upper result bits, returns {rem, root}
    function automatic logic [26:0] sqrt_hi(input logic [17:0] v);
        logic [17:0] rem;
        logic [8:0]  r;
        logic [17:0] trial;
        rem = v;
        r   = '0;
        for (int b = 8; b >= 5; b--)
        begin
            trial = ({9'd0, r} << (b + 1)) | (18'd1 << (2 * b));
            if (rem >= trial)
            begin
                rem = rem - trial;
                r   = r | (9'd1 << b);
            end
        end
        return {rem, r};
    endfunction

    // lower result bits of the same square root
    function automatic logic [8:0] sqrt_lo(input logic [17:0] rem_in, input logic [8:0] r_in);
        logic [17:0] rem;
        logic [8:0]  r;
        logic [17:0] trial;
        rem = rem_in;
        r   = r_in;
        for (int b = 4; b >= 0; b--)
        begin
            trial = ({9'd0, r} << (b + 1)) | (18'd1 << (2 * b));
            if (rem >= trial)
            begin
                rem = rem - trial;
                r   = r | (9'd1 << b);
            end
        end
        return r;
    endfunction

endpackage

[sv/vmf_if.sv]
// ----------------------------------------------------------------------------
// vmf_in_if / vmf_out_if
// valid/ready channels for pixels and results
// ----------------------------------------------------------------------------
interface vmf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
    modport source (output valid, in_red, in_green, in_blue, input ready);
    modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface vmf_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic        run_last;
    modport source (output valid, out_row, out_col, out_red, out_green, out_blue,
                    run_last, input ready);
    modport sink (input valid, out_row, out_col, out_red, out_green, out_blue,
                  run_last, output ready);
endinterface

[sv/vector_median_filter_3x3_rgb.sv]
// interior centers run the 81-term distance sweep through one shared three-stage
//   square-root pipe before their first result word, other positions skip it;
//   one result word per cycle after that while result_out is ready; a new pixel
//   is taken only once every result word of the last pixel has been taken
// reset: counters cleared, size 1024x1024; line stores hold no reset value
// ----------------------------------------------------------------------------
// vector_median_filter_3x3_rgb
// 3x3 vector median filter over a raster rgb stream
// ----------------------------------------------------------------------------
module vector_median_filter_3x3_rgb (
    input  logic                          clk,
    input  logic                          rst_n,
    vmf_in_if.sink                        pixel_in,
    vmf_out_if.source                     result_out,
    input  logic                          cfg_we,
    input  logic [vmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vmf_pkg::CFG_W-1:0]     cfg_data
);
    import vmf_pkg::*;

    dp_cmd_t cmd;
    logic    interior, res_done, res_start;
    result_t res;

    vmf_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(pixel_in.valid), .in_ready(pixel_in.ready),
        .interior(interior), .res_done(res_done), .cmd(cmd), .res_start(res_start)
    );

    vmf_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd(cmd), .res_start(res_start),
        .in_pix({pixel_in.in_red, pixel_in.in_green, pixel_in.in_blue}),
        .interior(interior), .res_done(res_done), .res_valid(result_out.valid),
        .res_ready(result_out.ready), .res(res)
    );

    assign result_out.out_row   = res.row;
    assign result_out.out_col   = res.col;
    assign result_out.out_red   = res.red;
    assign result_out.out_green = res.green;
    assign result_out.out_blue  = res.blue;
    assign result_out.run_last  = res.run_last;
endmodule

[sv/vmf_ram.sv]
// ----------------------------------------------------------------------------
// vmf_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module vmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

[sv/vmf_ctrl.sv]
// ----------------------------------------------------------------------------
// vmf_ctrl
// sequencer: read line stores, sweep 81 distance terms on interior centers, emit results
// ----------------------------------------------------------------------------
module vmf_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      interior,
    input  logic                      res_done,
    output vmf_pkg::dp_cmd_t          cmd,
    output logic                      res_start
);
    import vmf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_CAPT  = 7'b0000100,
        S_SUM   = 7'b0001000,
        S_FLUSH = 7'b0010000,
        S_EMIT  = 7'b0100000,
        S_STORE = 7'b1000000
    } state_t;

    state_t     state_reg, state_next;
    logic [3:0] k_reg, k_next, c_reg, c_next;

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        c_next        = c_reg;
        cmd           = '0;
        cmd.k         = k_reg;
        cmd.c         = c_reg;
        in_ready      = 1'b0;
        res_start     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
                state_next = S_CAPT;
            S_CAPT:
            begin
                cmd.capture   = 1'b1;
                cmd.clear_acc = 1'b1;
                k_next        = '0;
                c_next        = '0;
                state_next    = interior ? S_SUM : S_EMIT;
            end
            S_SUM:
            begin
                cmd.acc = 1'b1;
                if (c_reg == 4'(WIN_N - 1))
                begin
                    cmd.choose = 1'b1;
                    c_next     = '0;
                    if (k_reg == 4'(WIN_N - 1))
                        state_next = S_FLUSH;
                    else
                        k_next = k_reg + 4'd1;
                end
                else
                    c_next = c_reg + 4'd1;
            end
            S_FLUSH:
            begin
                if (c_reg == 4'(SQ_PIPE - 1))
                begin
                    c_next     = '0;
                    state_next = S_EMIT;
                end
                else
                    c_next = c_reg + 4'd1;
            end
            S_EMIT:
            begin
                res_start  = 1'b1;
                state_next = S_STORE;
            end
            S_STORE:
            begin
                if (res_done)
                begin
                    cmd.store  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            k_reg     <= '0;
            c_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
        end
    end
endmodule

[sv/vmf_dp.sv]
// ----------------------------------------------------------------------------
// vmf_dp
// datapath: counters, line stores, window, distance accumulator, result queue
// ----------------------------------------------------------------------------
module vmf_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [vmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vmf_pkg::CFG_W-1:0]    cfg_data,
    input  vmf_pkg::dp_cmd_t             cmd,
    input  logic                         res_start,
    input  vmf_pkg::pixel_t              in_pix,
    output logic                         interior,
    output logic                         res_done,
    output logic                         res_valid,
    input  logic                         res_ready,
    output vmf_pkg::result_t             res
);
    import vmf_pkg::*;

    logic [10:0]      fw_reg;
    logic [12:0]      fh_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W:0]   w_eff;
    logic [ROW_W:0]   h_eff;
    logic [COL_W-1:0] j, wl;
    logic [ROW_W-1:0] i, hl;
    pixel_t           pix_reg;
    pixel_t           win_reg [WIN_N];
    pixel_t           up_rd, mid_rd;
    logic             int_reg;
    logic [SUM_W-1:0] acc_reg, best_reg;
    pixel_t           sel_reg;
    logic [8:0]       dist_reg;
    logic             dv_reg;
    logic             choose_d_reg;
    logic [3:0]       kd_reg;
    result_t          q_reg [3];
    logic [2:0]       qv_reg;
    logic             busy_reg;

    always_comb
    begin
        if (fw_reg < 11'd3)
            w_eff = 11'd3;
        else if (fw_reg > 11'(MAX_WIDTH))
            w_eff = 11'(MAX_WIDTH);
        else
            w_eff = fw_reg;
        if (fh_reg < 13'd3)
            h_eff = 13'd3;
        else if (fh_reg > 13'(MAX_HEIGHT))
            h_eff = 13'(MAX_HEIGHT);
        else
            h_eff = fh_reg;
        wl = COL_W'(w_eff - 11'd1);
        hl = ROW_W'(h_eff - 13'd1);
        j  = (col_reg > wl) ? wl : col_reg;
        i  = (row_reg > hl) ? hl : row_reg;
    end

    assign interior = (i >= ROW_W'(2)) && (j >= COL_W'(2));

    vmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk(clk), .we(cmd.store), .addr(j), .wdata(mid_rd), .rdata(up_rd)
    );
    pixel_t mid_q;
    vmf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
        .clk(clk), .we(cmd.store), .addr(j), .wdata(pix_reg), .rdata(mid_q)
    );
    pixel_t up_hold_reg, mid_hold_reg;
    assign mid_rd = mid_hold_reg;

    // window: 0..2 top row, 3..5 middle, 6..8 bottom; store order kept in model form
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            pix_reg <= in_pix;
        if (cmd.capture)
        begin
            up_hold_reg  <= up_rd;
            mid_hold_reg <= mid_q;
            win_reg[2]   <= up_rd;
            win_reg[5]   <= mid_q;
            win_reg[8]   <= pix_reg;
        end
        if (cmd.store)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[3] <= win_reg[4];
            win_reg[6] <= win_reg[7];
            win_reg[1] <= up_hold_reg;
            win_reg[4] <= mid_hold_reg;
            win_reg[7] <= pix_reg;
        end
    end

    // distance stage, two square-root stages, then accumulate stage
    logic [7:0]  dr, dg, db;
    logic [17:0] sq;
    pixel_t      pa, pb;
    always_comb
    begin
        pa = win_reg[cmd.k];
        pb = win_reg[cmd.c];
        dr = (pa[23:16] > pb[23:16]) ? pa[23:16] - pb[23:16] : pb[23:16] - pa[23:16];
        dg = (pa[15:8] > pb[15:8]) ? pa[15:8] - pb[15:8] : pb[15:8] - pa[15:8];
        db = (pa[7:0] > pb[7:0]) ? pa[7:0] - pb[7:0] : pb[7:0] - pa[7:0];
        sq = 18'({8'd0, dr} * {8'd0, dr}) + 18'({8'd0, dg} * {8'd0, dg})
           + 18'({8'd0, db} * {8'd0, db});
    end

    logic [17:0] sq_reg;
    logic        sqv_reg, sqc_reg;
    logic [3:0]  sqk_reg;
    logic [26:0] sqh_reg;
    logic        hv_reg, hc_reg;
    logic [3:0]  hk_reg;
    logic [SUM_W-1:0] tot;
    assign tot = acc_reg + SUM_W'(dist_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqv_reg      <= 1'b0;
            hv_reg       <= 1'b0;
            dv_reg       <= 1'b0;
            sqc_reg      <= 1'b0;
            hc_reg       <= 1'b0;
            choose_d_reg <= 1'b0;
        end
        else
        begin
            sqv_reg      <= cmd.acc;
            sqc_reg      <= cmd.choose;
            hv_reg       <= sqv_reg;
            hc_reg       <= sqc_reg;
            dv_reg       <= hv_reg;
            choose_d_reg <= hc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg   <= sq;
        sqk_reg  <= cmd.k;
        hk_reg   <= sqk_reg;
        kd_reg   <= hk_reg;
        sqh_reg  <= sqrt_hi(sq_reg);
        dist_reg <= sqrt_lo(sqh_reg[26:9], sqh_reg[8:0]);
        if (cmd.capture)
        begin
            int_reg <= interior;
            acc_reg <= '0;
            sel_reg <= '0;
        end
        else if (dv_reg)
        begin
            if (choose_d_reg)
            begin
                acc_reg <= '0;
                if (kd_reg == 4'd0 || tot < best_reg)
                begin
                    best_reg <= tot;
                    sel_reg  <= win_reg[kd_reg];
                end
            end
            else
                acc_reg <= tot;
        end
    end

    // result queue, loaded at emit, once the square-root pipe has drained
    result_t    r0, r1, r2;
    logic [2:0] want;
    pixel_t     cen;
    always_comb
    begin
        cen     = int_reg ? sel_reg : '0;
        want[0] = (i >= ROW_W'(1)) && (j >= COL_W'(1));
        want[1] = (i >= ROW_W'(1)) && (j == wl);
        want[2] = (i == hl);
        r0 = '{row: i - ROW_W'(1), col: j - COL_W'(1), red: cen[23:16],
               green: cen[15:8], blue: cen[7:0], run_last: !(want[1] || want[2])};
        r1 = '{row: i - ROW_W'(1), col: wl, red: 8'd0, green: 8'd0, blue: 8'd0,
               run_last: !want[2]};
        r2 = '{row: i, col: j, red: 8'd0, green: 8'd0, blue: 8'd0, run_last: 1'b1};
    end

    assign res_valid = |qv_reg;
    assign res       = qv_reg[0] ? q_reg[0] : (qv_reg[1] ? q_reg[1] : q_reg[2]);
    assign res_done  = busy_reg && !res_valid;

    logic [2:0] pop;
    always_comb
    begin
        pop = '0;
        if (res_ready)
        begin
            if (qv_reg[0])
                pop[0] = 1'b1;
            else if (qv_reg[1])
                pop[1] = 1'b1;
            else
                pop[2] = qv_reg[2];
        end
    end

    logic emit_d_reg;
    always_ff @(posedge clk)
    begin
        if (res_start)
        begin
            q_reg[0] <= r0;
            q_reg[1] <= r1;
            q_reg[2] <= r2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg     <= 11'd1024;
            fh_reg     <= 13'd1024;
            col_reg    <= '0;
            row_reg    <= '0;
            qv_reg     <= '0;
            busy_reg   <= 1'b0;
            emit_d_reg <= 1'b0;
        end
        else
        begin
            emit_d_reg <= res_start;
            busy_reg   <= cmd.store ? 1'b0 : (busy_reg || emit_d_reg);
            if (res_start)
                qv_reg <= want;
            else
                qv_reg <= qv_reg & ~pop;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  fw_reg <= cfg_data[10:0];
                    REG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    default:          fw_reg <= fw_reg;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (cmd.store)
            begin
                if (j == wl)
                begin
                    col_reg <= '0;
                    row_reg <= (i == hl) ? '0 : i + ROW_W'(1);
                end
                else
                begin
                    col_reg <= j + COL_W'(1);
                    row_reg <= i;
                end
            end
        end
    end
endmodule

[sv/vmf_checker.sv]
// ----------------------------------------------------------------------------
// vmf_checker
// port-level checks on the filter
// ----------------------------------------------------------------------------
module vmf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       run_last,
    input logic [9:0] out_col
);
    a_no_take_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while results pending");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid) else $error("result dropped");
    a_col_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_col)) else $error("column changed");
    a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second pixel taken");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("run ended without last mark");
endmodule

bind vector_median_filter_3x3_rgb vmf_checker u_vmf_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(pixel_in.valid), .in_ready(pixel_in.ready),
    .out_valid(result_out.valid), .out_ready(result_out.ready),
    .run_last(result_out.run_last), .out_col(result_out.out_col)
);

[tb/tb_vector_median_filter_3x3_rgb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_vector_median_filter_3x3_rgb
// Self-checking bench for the 3x3 rgb vector median filter. Pixel frames of
// several sizes, including saturated and maximum sizes, are streamed in with
// random gaps and output back-pressure. A model of the filter predicts every
// result word, and each word is checked against it in order.
// ----------------------------------------------------------------------------
module tb_vector_median_filter_3x3_rgb;

    import vmf_pkg::*;

    localparam int MAX_REPORTS = 10;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    vmf_in_if  pin ();
    vmf_out_if rout ();

    vector_median_filter_3x3_rgb dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_in   (pin),
        .result_out (rout),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // filter model state
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    pixel_t      upper_row [MAX_WIDTH];
    pixel_t      middle_row [MAX_WIDTH];
    pixel_t      win_cols [6];
    int unsigned next_row;
    int unsigned next_col;

    result_t     expected_q [$];
    bit          idle_on;
    int          mismatches;
    int          words_seen;
    int          pixels_sent;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic int unsigned floor_sqrt(input int unsigned v);
        int unsigned r;
        int unsigned bitv;
        r = 0;
        bitv = 1 << 30;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= r + bitv)
            begin
                v = v - (r + bitv);
                r = (r >> 1) + bitv;
            end
            else
                r = r >> 1;
            bitv = bitv >> 2;
        end
        return r;
    endfunction

    function automatic int unsigned color_distance(input pixel_t a, input pixel_t b);
        int dr;
        int dg;
        int db;
        dr = int'(a[23:16]) - int'(b[23:16]);
        dg = int'(a[15:8]) - int'(b[15:8]);
        db = int'(a[7:0]) - int'(b[7:0]);
        return floor_sqrt(dr * dr + dg * dg + db * db);
    endfunction

    function automatic void expect_word(input int unsigned row, input int unsigned col,
                                        input pixel_t pix);
        result_t w;
        w.row = row[ROW_W-1:0];
        w.col = col[COL_W-1:0];
        w.red = pix[23:16];
        w.green = pix[15:8];
        w.blue = pix[7:0];
        w.run_last = 1'b0;
        expected_q.push_back(w);
    endfunction

    function automatic void predict_filter(input pixel_t pix);
        int unsigned w;
        int unsigned h;
        int unsigned i;
        int unsigned j;
        int unsigned best;
        int unsigned s;
        int          n;
        pixel_t      win [9];
        pixel_t      sel;
        w = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
        h = (height_reg < 3) ? 3 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
        i = next_row;
        j = next_col;
        n = expected_q.size();
        if (j >= w)
            j = w - 1;
        if (i >= h)
            i = h - 1;
        for (int r = 0; r < 3; r++)
        begin
            win[r * 3] = win_cols[r];
            win[r * 3 + 1] = win_cols[3 + r];
        end
        win[2] = upper_row[j];
        win[5] = middle_row[j];
        win[8] = pix;
        if (i >= 1 && j >= 1)
        begin
            sel = '0;
            best = 0;
            if (i >= 2 && j >= 2)
            begin
                for (int k = 0; k < 9; k++)
                begin
                    s = 0;
                    for (int c = 0; c < 9; c++)
                        s += color_distance(win[k], win[c]);
                    if (k == 0 || s < best)
                    begin
                        best = s;
                        sel = win[k];
                    end
                end
            end
            expect_word(i - 1, j - 1, sel);
        end
        if (i >= 1 && j == w - 1)
            expect_word(i - 1, w - 1, '0);
        if (i == h - 1)
            expect_word(i, j, '0);
        if (expected_q.size() > n)
            expected_q[expected_q.size() - 1].run_last = 1'b1;
        upper_row[j] = middle_row[j];
        middle_row[j] = pix;
        for (int r = 0; r < 3; r++)
        begin
            win_cols[r] = win_cols[3 + r];
            win_cols[3 + r] = win[r * 3 + 2];
        end
        if (j + 1 >= w)
        begin
            next_col = 0;
            next_row = (i + 1 >= h) ? 0 : i + 1;
        end
        else
        begin
            next_col = j + 1;
            next_row = i;
        end
    endfunction

    // output sink with bursty back-pressure
    initial
    begin
        rout.ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 11) == 0)
            begin
                rout.ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            rout.ready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && rout.valid && rout.ready)
        begin
            got.row = rout.out_row;
            got.col = rout.out_col;
            got.red = rout.out_red;
            got.green = rout.out_green;
            got.blue = rout.out_blue;
            got.run_last = rout.run_last;
            words_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected word: row %0d col %0d rgb %h %h %h last %b",
                             got.row, got.col, got.red, got.green, got.blue, got.run_last);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected row %0d col %0d rgb %h %h %h last %b, got row %0d col %0d rgb %h %h %h last %b",
                                 want.row, want.col, want.red, want.green, want.blue,
                                 want.run_last, got.row, got.col, got.red, got.green,
                                 got.blue, got.run_last);
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_pixel(input pixel_t pix);
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            pin.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        pin.valid = 1'b1;
        pin.in_red = pix[23:16];
        pin.in_green = pix[15:8];
        pin.in_blue = pix[7:0];
        do
            @(posedge clk);
        while (!pin.ready);
        predict_filter(pix);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic drain;
        pin.valid = 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        drain();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value[CFG_W-1:0];
        if (idx == REG_FRAME_WIDTH)
            width_reg = value[10:0];
        else
            height_reg = value[12:0];
        next_row = 0;
        next_col = 0;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_size(input int unsigned w, input int unsigned h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    function automatic pixel_t random_pixel(input int style, input pixel_t base);
        pixel_t p;
        case (style)
            0: p = pixel_t'($urandom);
            1:
            begin
                if ($urandom_range(0, 5) == 0)
                    p = pixel_t'($urandom);
                else
                    for (int c = 0; c < 3; c++)
                        p[c*8 +: 8] = 8'(int'(base[c*8 +: 8]) + $urandom_range(0, 6) - 3);
            end
            default:
                for (int c = 0; c < 3; c++)
                    p[c*8 +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
        endcase
        return p;
    endfunction

    task automatic send_frame(input int unsigned count, input int style);
        pixel_t base;
        base = pixel_t'($urandom);
        for (int n = 0; n < count; n++)
            send_pixel(random_pixel(style, base));
    endtask

    task automatic test_directed;
        pixel_t corner_set [9] = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00,
                                   24'h0000ff, 24'h808080, 24'hffff00, 24'h00ffff,
                                   24'h7f7f7f};
        set_size(3, 3);
        foreach (corner_set[k])
            send_pixel(corner_set[k]);
        // equal sums pick the first window pixel, one outlier
        set_size(4, 3);
        for (int n = 0; n < 12; n++)
            send_pixel(n == 6 ? 24'hffffff : 24'h406080);
    endtask

    task automatic test_size_saturation;
        set_size(0, 2);
        send_frame(9, 0);
        set_size(1, 8191);
        send_frame(30, 1);
        set_size(3, 4096);
        send_frame(12, 2);
    endtask

    task automatic test_widest_frame;
        idle_on = 1'b0;
        set_size(2047, 3);
        send_frame(40, 1);
        set_size(MAX_WIDTH, 1);
        send_frame(20, 0);
        idle_on = 1'b1;
    endtask

    task automatic test_random_frames;
        int unsigned w;
        int unsigned h;
        int unsigned count;
        int unsigned remaining;
        int          start;
        start = pixels_sent;
        while (pixels_sent - start < 160)
        begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 20) : $urandom_range(3, 7);
            h = $urandom_range(3, 6);
            set_size(w, h);
            count = w * h;
            // occasionally break off a frame or run into the next one
            if ($urandom_range(0, 4) == 0)
                count = $urandom_range(1, 2 * w * h);
            remaining = 160 - (pixels_sent - start);
            if (count > remaining)
                count = remaining;
            send_frame(count, $urandom_range(0, 2));
        end
    endtask

    task automatic test_streaming;
        idle_on = 1'b0;
        set_size(5, 4);
        send_frame(40, 1);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        pin.valid = 1'b0;
        pin.in_red = '0;
        pin.in_green = '0;
        pin.in_blue = '0;
        width_reg = 11'd1024;
        height_reg = 13'd1024;
        next_row = 0;
        next_col = 0;
        foreach (upper_row[k])
        begin
            upper_row[k] = '0;
            middle_row[k] = '0;
        end
        foreach (win_cols[k])
            win_cols[k] = '0;
        idle_on = 1'b1;
        mismatches = 0;
        words_seen = 0;
        pixels_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_size_saturation();
        test_widest_frame();
        test_random_frames();
        test_streaming();

        drain();
        $display("covered directed, saturated, widest and random frames with stalls");
        $display("pixels sent %0d, result words checked %0d, mismatches %0d",
                 pixels_sent, words_seen, mismatches);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("vector_median_filter_3x3_rgb regression: pass");
        else
            $display("vector_median_filter_3x3_rgb regression: fail");
        $finish;
    end

    initial
    begin
        #80_000_000;
        $display("timeout with %0d words outstanding", expected_q.size());
        $display("vector_median_filter_3x3_rgb regression: fail");
        $finish;
    end

endmodule
